FILE: design/fioms_pkg.sv
// Shared types, codes and constants for the fixed I/O mapping slot allocator.
`default_nettype none

package fioms_pkg;

    localparam int ADDR_W     = 64;
    localparam int SIZE_W     = 16;
    localparam int FLAGS_W    = 12;
    localparam int IDX_W      = 6;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;
    // page count per request; holds up to 127 pages
    localparam int PAGE_CNT_W = 7;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd3;

    localparam logic OP_MAP   = 1'b0;
    localparam logic OP_UNMAP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_FLAGS  = 1'b1;

    localparam logic [ADDR_W-1:0]  WINDOW_BASE_RST = 64'hFFFF_FFFF_FFF8_6000;
    localparam logic [FLAGS_W-1:0] PAGE_FLAGS_RST  = 12'h003;

    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] size;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   mapped_address;
        logic                pte_write;
        logic [IDX_W-1:0]    pte_index;
        logic [ADDR_W-1:0]   pte_value;
        logic                invalidate;
        logic [ADDR_W-1:0]   invalidate_address;
        logic                last;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic prep;
        logic check;
        logic match;
        logic commit;
        logic emit;
        logic last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic                  out_free;
        logic                  err;
        logic [PAGE_CNT_W-1:0] pages;
    } ctrl_sts_t;

endpackage

`default_nettype wire

FILE: design/fioms_datapath.sv
// Datapath: request registers, free-slot ring, slot tables, config and result register.
`default_nettype none

module fioms_datapath #(
    parameter int SLOTS          = 8,
    parameter int PAGES_PER_SLOT = 8,
    parameter int PAGE_SHIFT     = 12
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire fioms_pkg::req_t                    s_data,
    input  wire logic                               cfg_valid,
    input  wire logic [fioms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [fioms_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire fioms_pkg::ctrl_cmd_t               cmd,
    output fioms_pkg::ctrl_sts_t                    sts,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output fioms_pkg::rsp_t                         m_data
);

    localparam int SW    = $clog2(SLOTS);
    localparam int FCW   = $clog2(SLOTS + 1);
    localparam int PNW   = $clog2(SLOTS * PAGES_PER_SLOT);
    localparam int PGW   = ((PAGE_SHIFT > 16) ? PAGE_SHIFT : 16) + 2;
    localparam int PRW   = PGW - PAGE_SHIFT;
    localparam int PRODW = SW + 7;
    localparam int CW    = fioms_pkg::PAGE_CNT_W;

    localparam logic [63:0]    WIN_SPAN   = 64'(SLOTS * PAGES_PER_SLOT) << PAGE_SHIFT;
    localparam logic [63:0]    PAGE_BYTES = 64'd1 << PAGE_SHIFT;
    localparam logic [PGW-1:0] OFS_MASK   = PGW'((64'd1 << PAGE_SHIFT) - 64'd1);

    // configuration
    logic [63:0] window_base_reg;
    logic [11:0] page_flags_reg;

    // request
    logic        op_reg;
    logic [63:0] addr_reg;
    logic [15:0] size_reg;

    // first evaluation stage
    logic           arg_bad_reg;
    logic           below_reg;
    logic [63:0]    diff_reg;
    logic [PRW-1:0] pages_raw_reg;
    logic [SW-1:0]  take_slot_reg;

    // decision stage
    logic [1:0]    status_reg;
    logic [SW-1:0] slot_reg;
    logic [CW-1:0] pages_reg;

    // emission
    logic [63:0] mapped_reg;
    logic [63:0] page_addr_reg;
    logic [5:0]  idx_reg;

    // allocator state
    logic [SW-1:0]  ring_reg [SLOTS];
    logic [SW-1:0]  take_ptr_reg;
    logic [SW-1:0]  ret_ptr_reg;
    logic [FCW-1:0] free_cnt_reg;
    logic [63:0]    slot_addr_reg [SLOTS];
    logic [15:0]    slot_size_reg [SLOTS];

    logic            m_valid_reg;
    fioms_pkg::rsp_t rsp_reg;
    fioms_pkg::rsp_t rsp_next;

    logic [64:0]      sum_ext;
    logic [64:0]      sub_ext;
    logic [PGW-1:0]   pg_sum;
    logic [SW-1:0]    take_ptr_inc;
    logic [SW-1:0]    ret_ptr_inc;
    logic [PNW-1:0]   pn;
    logic [SW-1:0]    slot_calc;
    logic             out_of_range;
    logic             pages_over;
    logic [CW-1:0]    pages_sat;
    logic [1:0]       status_check;
    logic             mismatch;
    logic [PRODW-1:0] slot_prod;
    logic [63:0]      mapped_next;
    logic             commit_ok;

    assign sum_ext = {1'b0, addr_reg} + {49'd0, size_reg};
    assign sub_ext = {1'b0, addr_reg} - {1'b0, window_base_reg};
    assign pg_sum  = PGW'(addr_reg[PAGE_SHIFT-1:0]) + PGW'(size_reg) + OFS_MASK;

    assign take_ptr_inc = (take_ptr_reg == SW'(SLOTS - 1)) ? '0 : take_ptr_reg + SW'(1);
    assign ret_ptr_inc  = (ret_ptr_reg == SW'(SLOTS - 1)) ? '0 : ret_ptr_reg + SW'(1);

    // slot = page number / PAGES_PER_SLOT, by constant thresholds
    assign pn = diff_reg[PAGE_SHIFT +: PNW];
    always_comb begin
        slot_calc = '0;
        for (int k = 1; k < SLOTS; k++) begin
            if ({1'b0, pn} >= (PNW + 1)'(k * PAGES_PER_SLOT)) begin
                slot_calc = SW'(k);
            end
        end
    end

    assign out_of_range = (diff_reg >= WIN_SPAN);
    assign pages_over   = (32'(pages_raw_reg) > 32'(PAGES_PER_SLOT));
    assign pages_sat    = pages_over ? CW'(PAGES_PER_SLOT) : CW'(pages_raw_reg);

    always_comb begin
        if (op_reg == fioms_pkg::OP_MAP) begin
            if (arg_bad_reg || pages_over) begin
                status_check = fioms_pkg::ST_INVALID;
            end else if (free_cnt_reg == '0) begin
                status_check = fioms_pkg::ST_NO_SLOT;
            end else begin
                status_check = fioms_pkg::ST_OK;
            end
        end else begin
            if (arg_bad_reg || below_reg || out_of_range) begin
                status_check = fioms_pkg::ST_INVALID;
            end else if (free_cnt_reg >= FCW'(SLOTS)) begin
                status_check = fioms_pkg::ST_NOT_FOUND;
            end else begin
                status_check = fioms_pkg::ST_OK;
            end
        end
    end

    // a free slot holds address zero and never matches a legal request
    assign mismatch = (slot_addr_reg[slot_reg] != addr_reg) ||
                      (slot_size_reg[slot_reg] != size_reg);

    assign slot_prod   = PRODW'(slot_reg) * PRODW'(PAGES_PER_SLOT);
    assign mapped_next = window_base_reg +
                         ((64'(slot_prod) << PAGE_SHIFT) | 64'(addr_reg[PAGE_SHIFT-1:0]));
    assign commit_ok   = cmd.commit && (status_reg == fioms_pkg::ST_OK);

    always_comb begin
        rsp_next        = '0;
        rsp_next.status = status_reg;
        rsp_next.last   = cmd.last;
        if (status_reg == fioms_pkg::ST_OK) begin
            rsp_next.pte_write = 1'b1;
            rsp_next.pte_index = idx_reg;
            if (op_reg == fioms_pkg::OP_MAP) begin
                rsp_next.mapped_address = mapped_reg;
                rsp_next.pte_value      = page_addr_reg | 64'(page_flags_reg);
            end else begin
                rsp_next.invalidate         = 1'b1;
                rsp_next.invalidate_address = page_addr_reg;
            end
        end
    end

    // request and evaluation registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= s_data.operation;
            addr_reg <= s_data.address;
            size_reg <= s_data.size;
        end
        if (cmd.prep) begin
            arg_bad_reg   <= (addr_reg == '0) || (size_reg == '0) || sum_ext[64];
            below_reg     <= sub_ext[64];
            diff_reg      <= sub_ext[63:0];
            pages_raw_reg <= pg_sum[PGW-1:PAGE_SHIFT];
            take_slot_reg <= ring_reg[take_ptr_inc];
        end
        if (cmd.check) begin
            status_reg <= status_check;
            slot_reg   <= (op_reg == fioms_pkg::OP_MAP) ? take_slot_reg : slot_calc;
            pages_reg  <= pages_sat;
        end
        if (cmd.match && (op_reg == fioms_pkg::OP_UNMAP) &&
            (status_reg == fioms_pkg::ST_OK) && mismatch) begin
            status_reg <= fioms_pkg::ST_NOT_FOUND;
        end
        if (cmd.commit) begin
            mapped_reg    <= mapped_next;
            page_addr_reg <= {addr_reg[63:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
            idx_reg       <= slot_prod[5:0];
        end
        if (cmd.emit) begin
            page_addr_reg <= page_addr_reg + PAGE_BYTES;
            idx_reg       <= idx_reg + 6'd1;
        end
        if (cmd.emit) begin
            rsp_reg <= rsp_next;
        end
    end

    // allocator state, configuration and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_base_reg <= fioms_pkg::WINDOW_BASE_RST;
            page_flags_reg  <= fioms_pkg::PAGE_FLAGS_RST;
            take_ptr_reg    <= SW'(SLOTS - 1);
            ret_ptr_reg     <= SW'(SLOTS - 1);
            free_cnt_reg    <= FCW'(SLOTS);
            m_valid_reg     <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                ring_reg[i]      <= SW'(i);
                slot_addr_reg[i] <= '0;
                slot_size_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    fioms_pkg::REG_WINDOW_BASE: window_base_reg <= cfg_data;
                    fioms_pkg::REG_PAGE_FLAGS:  page_flags_reg  <= cfg_data[11:0];
                    default: ;
                endcase
            end
            if (commit_ok) begin
                if (op_reg == fioms_pkg::OP_MAP) begin
                    free_cnt_reg            <= free_cnt_reg - FCW'(1);
                    take_ptr_reg            <= take_ptr_inc;
                    slot_addr_reg[slot_reg] <= mapped_next;
                    slot_size_reg[slot_reg] <= size_reg;
                end else begin
                    free_cnt_reg            <= free_cnt_reg + FCW'(1);
                    ret_ptr_reg             <= ret_ptr_inc;
                    ring_reg[ret_ptr_inc]   <= slot_reg;
                    slot_addr_reg[slot_reg] <= '0;
                    slot_size_reg[slot_reg] <= '0;
                end
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.out_free = !m_valid_reg || m_ready;
    assign sts.err      = (status_reg != fioms_pkg::ST_OK);
    assign sts.pages    = pages_reg;

    assign m_valid = m_valid_reg;
    assign m_data  = rsp_reg;

endmodule

`default_nettype wire

FILE: design/fioms_ctrl.sv
// Controller: sequences evaluation, commit and one result per page, or a single error result.
`default_nettype none

module fioms_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    output fioms_pkg::ctrl_cmd_t       cmd,
    input  wire fioms_pkg::ctrl_sts_t  sts
);

    localparam int CW = fioms_pkg::PAGE_CNT_W;

    typedef enum logic [2:0] {
        IDLE,
        PREP,
        CHECK,
        MATCH,
        COMMIT,
        EMIT
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          s_ready_reg;
    logic          last_page;

    assign last_page = sts.err || (CW'(cnt_reg + CW'(1)) == sts.pages);

    always_comb begin
        cmd         = '0;
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = PREP;
                end
            end
            PREP: begin
                cmd.prep   = 1'b1;
                state_next = CHECK;
            end
            CHECK: begin
                cmd.check  = 1'b1;
                state_next = MATCH;
            end
            MATCH: begin
                cmd.match  = 1'b1;
                state_next = COMMIT;
            end
            COMMIT: begin
                cmd.commit = 1'b1;
                cnt_next   = '0;
                state_next = EMIT;
            end
            EMIT: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.last = last_page;
                    if (last_page) begin
                        state_next = IDLE;
                    end else begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            cnt_reg     <= '0;
            s_ready_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            s_ready_reg <= (state_next == IDLE);
        end
    end

    assign s_ready = s_ready_reg;

endmodule

`default_nettype wire

FILE: design/fixed_io_mapping_slot_allocator.sv
// Top level of the fixed I/O mapping slot allocator.
// Usage:
//   s_valid/s_ready/s_data carry one map or unmap request per transaction.
//   m_valid/m_ready/m_data return the results: one per page of the range
//   (page table write, plus an invalidate on unmap), or a single error result.
//   m_data.last marks the final result of a request.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write window_base (index 0) and
//   page_flags (index 1); cfg_ready is always high. Write only while idle.
// Timing:
//   A request passes the states PREP (argument check), CHECK (range/slot
//   decode), MATCH (stored-entry compare) and COMMIT, then EMIT gives one
//   result per cycle while the output register is free. A new request is
//   accepted only after the last result of the previous one is loaded.
//   The per-page emit step of the controller sets the rate.
// Reset:
//   aresetn (synchronous, active low) restores the free ring to slot order,
//   empties all slots and reloads both config registers; no sweep follows.
// Stall:
//   Results sit in an output register; while it is not taken the controller
//   holds the next result, and a new request is taken once the last one is
//   loaded even if it still waits.
`default_nettype none

module fixed_io_mapping_slot_allocator #(
    parameter int SLOTS          = 8,
    parameter int PAGES_PER_SLOT = 8,
    parameter int PAGE_SHIFT     = 12
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire fioms_pkg::req_t                   s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output fioms_pkg::rsp_t                        m_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [fioms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [fioms_pkg::CFG_DATA_W-1:0]  cfg_data
);

    fioms_pkg::ctrl_cmd_t cmd;
    fioms_pkg::ctrl_sts_t sts;

    // config registers take a write in any cycle
    assign cfg_ready = 1'b1;

    fioms_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    fioms_datapath #(
        .SLOTS          (SLOTS),
        .PAGES_PER_SLOT (PAGES_PER_SLOT),
        .PAGE_SHIFT     (PAGE_SHIFT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef SYNTHESIS
    // a result is never loaded over one that is still waiting
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid || m_ready))
        else $error("result loaded over a pending transaction");

    // no result goes out in the cycle right after a request is taken
    a_accept_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !cmd.emit)
        else $error("result emitted before request was evaluated");

    // error results stand alone
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != fioms_pkg::ST_OK)) |-> m_data.last)
        else $error("error result not marked last");

    // every successful result writes a page table entry
    a_ok_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.pte_write) |-> (m_data.status != fioms_pkg::ST_OK))
        else $error("ok result without page table write");
`endif

endmodule

`default_nettype wire
